@@ hdl/tci_pkg.sv @@
// Shared types, constants and tables for the track cone isolation block.
package tci_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    // square root unit: radicand width, root width, step counter width
    localparam int SQ_W  = 42;
    localparam int SQ_RW = SQ_W / 2;
    localparam int SQ_CW = $clog2(SQ_RW);

    // divider: dividend width, divisor width, step counter width
    localparam int DV_NW = 44;
    localparam int DV_DW = 20;
    localparam int DV_CW = $clog2(DV_NW);

    localparam int CFG_IW = 8;
    localparam int CFG_DW = 24;

    localparam logic [15:0] OUTER_RST  = 16'd819;
    localparam logic [15:0] INNER_RST  = 16'd61;
    localparam logic [19:0] MIN_PT_RST = 20'd0;
    localparam logic [23:0] PT_CUT_RST = 24'd3277;

    localparam logic signed [19:0] PI_Q16    = 20'sd205887;
    localparam logic signed [16:0] PI_Q12    = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
    localparam logic signed [16:0] VZ_WINDOW = 17'sd200;
    localparam logic [15:0]        LN2_Q16   = 16'd45426;
    localparam logic [15:0]        ETA_MAX   = 16'd32767;

    typedef enum logic [CFG_IW-1:0] {
        REG_OUTER_RADIUS = 8'd0,
        REG_INNER_RADIUS = 8'd1,
        REG_MIN_PT       = 8'd2,
        REG_PT_CUT       = 8'd3
    } t_cfg_reg;

    typedef enum logic {
        OP_ELECTRON = 1'b0,
        OP_TRACK    = 1'b1
    } t_op;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // arctangent of 2^-i in 2^-16 rad, rounded
    function automatic logic signed [19:0] atan_q16(input logic [4:0] idx);
        logic signed [19:0] v;
        case (idx)
            5'd0:    v = 20'sd51472;
            5'd1:    v = 20'sd30385;
            5'd2:    v = 20'sd16055;
            5'd3:    v = 20'sd8150;
            5'd4:    v = 20'sd4091;
            5'd5:    v = 20'sd2047;
            5'd6:    v = 20'sd1024;
            5'd7:    v = 20'sd512;
            5'd8:    v = 20'sd256;
            5'd9:    v = 20'sd128;
            5'd10:   v = 20'sd64;
            5'd11:   v = 20'sd32;
            5'd12:   v = 20'sd16;
            5'd13:   v = 20'sd8;
            5'd14:   v = 20'sd4;
            5'd15:   v = 20'sd2;
            5'd16:   v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/tci_if.sv @@
// Valid/ready channel interfaces for items, results and register writes.
interface tci_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [19:0] mom_x;
    logic signed [19:0] mom_y;
    logic signed [19:0] mom_z;
    logic signed [15:0] vertex_z;
    logic               last;
    modport source (output valid, op, mom_x, mom_y, mom_z, vertex_z, last, input ready);
    modport sink   (input valid, op, mom_x, mom_y, mom_z, vertex_z, last, output ready);
endinterface

interface tci_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pt_ratio;
    logic        isolated;
    logic [15:0] min_dr;
    logic [15:0] min_dr_veto;
    modport source (output valid, pt_ratio, isolated, min_dr, min_dr_veto, input ready);
    modport sink   (input valid, pt_ratio, isolated, min_dr, min_dr_veto, output ready);
endinterface

interface tci_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/tci_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
module tci_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [tci_pkg::SQ_W-1:0] i_rad,
    output tci_pkg::t_unit_stat      o_stat,
    output logic [tci_pkg::SQ_RW-1:0] o_root
);
    import tci_pkg::*;

    logic [SQ_W-1:0]  r_rad;
    logic [SQ_RW+1:0] r_rem;
    logic [SQ_RW-1:0] r_root;
    logic [SQ_CW-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [SQ_RW+3:0] rem_t;
    logic [SQ_RW+3:0] trial;
    logic             fits;

    assign rem_t = {r_rem, r_rad[SQ_W-1:SQ_W-2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign fits  = (rem_t >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == SQ_CW'(SQ_RW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[SQ_W-3:0], 2'b00};
            r_cnt <= r_cnt + 1'b1;
            if (fits) begin
                r_rem  <= SQ_RW'(0) + (rem_t[SQ_RW+1:0] - trial[SQ_RW+1:0]);
                r_root <= {r_root[SQ_RW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_t[SQ_RW+1:0];
                r_root <= {r_root[SQ_RW-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

endmodule

@@ hdl/tci_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
module tci_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tci_pkg::DV_NW-1:0] i_num,
    input  logic [tci_pkg::DV_DW-1:0] i_den,
    output tci_pkg::t_unit_stat       o_stat,
    output logic [tci_pkg::DV_NW-1:0] o_quo
);
    import tci_pkg::*;

    logic [DV_NW-1:0] r_num;
    logic [DV_DW-1:0] r_den;
    logic [DV_DW-1:0] r_rem;
    logic [DV_NW-1:0] r_quo;
    logic [DV_CW-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DV_DW:0] rem_t;
    logic [DV_DW:0] diff;
    logic           fits;

    assign rem_t = {r_rem, r_num[DV_NW-1]};
    assign diff  = rem_t - {1'b0, r_den};
    assign fits  = (rem_t >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DV_CW'(DV_NW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DV_NW-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            r_rem <= fits ? diff[DV_DW-1:0] : rem_t[DV_DW-1:0];
            r_quo <= {r_quo[DV_NW-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

@@ hdl/track_cone_isolation.sv @@
// Track isolation of an electron candidate: shared multiplier, root, CORDIC and divider.
// An electron passes the pt root, the momentum root, two log2 normalizations and the CORDIC;
// a kept track adds the deltaR root, a last track the divider and output (no divider
// when the candidate pt is zero). A zero-pt item skips the second root and both logs.
// A dropped track skips the roots, logs and CORDIC. One item at a time; ready again the cycle after it ends.
// Reset is synchronous, active low: registers to defaults, candidate zero, minima all ones.
module track_cone_isolation #(
    parameter int CORDIC_STEPS = tci_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tci_in_if.sink      i_in,
    tci_out_if.source   o_out,
    tci_cfg_if.sink     i_cfg
);
    import tci_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);

    typedef enum logic [4:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_W_PT, S_M4, S_M5, S_M6, S_W_P,
        S_LNORM, S_LSQ, S_LUPD, S_EMUL, S_ESET, S_PHI0, S_CORD, S_PHIR,
        S_POST, S_M7, S_M8, S_M9, S_W_DR, S_FIN, S_W_DIV, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_outer, r_inner;
    logic [19:0] r_min_pt;
    logic [23:0] r_pt_cut;

    // candidate and accumulators
    logic signed [15:0] r_cand_eta, r_cand_phi, r_cand_vz;
    logic [19:0]        r_cand_pt;
    logic [27:0]        r_sum;
    logic [15:0]        r_best, r_best_v;

    // current item
    logic               r_op, r_last;
    logic signed [19:0] r_px, r_py, r_pz;
    logic signed [15:0] r_vz;
    logic [19:0]        r_pt;
    logic signed [15:0] r_eta, r_phi;
    logic signed [16:0] r_deta, r_dphi;

    // shared multiplier
    logic signed [32:0] ma, mb;
    logic signed [65:0] r_prod;
    logic [40:0]        r_acc;

    // log2 sequencer
    logic [31:0] r_m;
    logic [4:0]  r_k;
    logic [15:0] r_frac;
    logic [3:0]  r_bit;
    logic        r_lsel;
    logic [20:0] r_l1;

    // CORDIC
    logic signed [31:0] r_x, r_y;
    logic signed [19:0] r_z;
    logic [IW-1:0]      r_iter;

    // output register
    logic        r_ov;
    logic [23:0] r_ratio;
    logic [23:0] r_oratio;
    logic        r_iso;
    logic [15:0] r_omin, r_ominv;

    // shared root and divider
    logic                 sq_start, dv_start;
    logic [SQ_W-1:0]      sq_rad;
    logic [SQ_RW-1:0]     sq_root;
    logic [DV_NW-1:0]     dv_quo;
    t_unit_stat           sq_stat, dv_stat;

    logic        in_acc;
    logic        out_load;
    logic signed [16:0] dvz;
    logic [19:0] az;
    logic [20:0] pz_neg;
    logic signed [31:0] xs, ys;
    logic signed [19:0] zr;
    logic [31:0] mnew;
    logic [15:0] frac_n;
    logic [20:0] dlog;
    logic [40:0] eta_t;
    logic [20:0] eta_e;
    logic [15:0] eta_c;
    logic signed [16:0] dphi_raw;
    logic [19:0] pt_sat;
    logic [15:0] dr;
    logic [28:0] sum_t;
    logic [23:0] ratio_sat;
    logic signed [31:0] x0, y0;

    assign in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_load = (r_state == S_OUT) && (!r_ov || o_out.ready);
    assign dvz      = 17'(i_in.vertex_z) - 17'(r_cand_vz);
    assign pz_neg   = 21'sd0 - 21'(r_pz);
    assign az       = r_pz[19] ? pz_neg[19:0] : r_pz;

    always_comb begin
        ma = '0;
        mb = '0;
        case (r_state)
            S_M1:    begin ma = 33'(r_px); mb = 33'(r_px); end
            S_M2:    begin ma = 33'(r_py); mb = 33'(r_py); end
            S_M4:    begin ma = $signed({13'b0, r_pt}); mb = $signed({13'b0, r_pt}); end
            S_M5:    begin ma = $signed({13'b0, az}); mb = $signed({13'b0, az}); end
            S_LSQ:   begin ma = $signed({1'b0, r_m}); mb = $signed({1'b0, r_m}); end
            S_EMUL:  begin ma = $signed({12'b0, dlog}); mb = $signed({17'b0, LN2_Q16}); end
            S_M7:    begin ma = 33'(r_deta); mb = 33'(r_deta); end
            S_M8:    begin ma = 33'(r_dphi); mb = 33'(r_dphi); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // radicand and start of the shared root, start of the divider
    assign sq_start = (r_state == S_M3) || (r_state == S_M6) || (r_state == S_M9);
    assign sq_rad   = 42'(r_acc) + 42'(r_prod[40:0]);
    assign dv_start = (r_state == S_FIN) && r_last && (r_cand_pt != '0);

    tci_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_stat  (sq_stat),
        .o_root  (sq_root)
    );

    tci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   ({r_sum, 16'b0}),
        .i_den   (r_cand_pt),
        .o_stat  (dv_stat),
        .o_quo   (dv_quo)
    );

    // datapath helpers
    assign xs     = r_x >>> 5'(r_iter);
    assign ys     = r_y >>> 5'(r_iter);
    assign zr     = r_z + 20'sd8;
    assign mnew   = r_prod[61:30];
    always_comb begin
        frac_n = r_frac;
        if (mnew[31]) frac_n[r_bit] = 1'b1;
    end
    assign dlog   = r_l1 - {r_k, r_frac};
    assign eta_t  = r_prod[40:0] + 41'd524288;
    assign eta_e  = eta_t[40:20];
    assign eta_c  = (eta_e > 21'(ETA_MAX)) ? ETA_MAX : eta_e[15:0];
    assign dphi_raw = 17'(r_phi) - 17'(r_cand_phi);
    assign pt_sat = (sq_root > 21'hFFFFF) ? 20'hFFFFF : sq_root[19:0];
    assign dr     = (sq_root > 21'h0FFFF) ? 16'hFFFF : sq_root[15:0];
    assign sum_t  = 29'(r_sum) + 29'(r_pt);
    assign ratio_sat = (dv_quo > 44'hFFFFFF) ? 24'hFFFFFF : dv_quo[23:0];
    assign x0     = {{4{r_px[19]}}, r_px, 8'b0};
    assign y0     = {{4{r_py[19]}}, r_py, 8'b0};

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_outer    <= OUTER_RST;
            r_inner    <= INNER_RST;
            r_min_pt   <= MIN_PT_RST;
            r_pt_cut   <= PT_CUT_RST;
            r_cand_eta <= '0;
            r_cand_phi <= '0;
            r_cand_vz  <= '0;
            r_cand_pt  <= '0;
            r_sum      <= '0;
            r_best     <= '1;
            r_best_v   <= '1;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (t_cfg_reg'(i_cfg.index))
                    REG_OUTER_RADIUS: r_outer  <= i_cfg.data[15:0];
                    REG_INNER_RADIUS: r_inner  <= i_cfg.data[15:0];
                    REG_MIN_PT:       r_min_pt <= i_cfg.data[19:0];
                    REG_PT_CUT:       r_pt_cut <= i_cfg.data;
                    default:          ;
                endcase
            end
            if (out_load)                 r_ov <= 1'b1;
            else if (r_ov && o_out.ready) r_ov <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op   <= i_in.op;
                        r_last <= i_in.last;
                        r_px   <= i_in.mom_x;
                        r_py   <= i_in.mom_y;
                        r_pz   <= i_in.mom_z;
                        r_vz   <= i_in.vertex_z;
                        // drop a track outside the vertex window
                        if (t_op'(i_in.op) == OP_TRACK && (dvz > VZ_WINDOW || dvz < -VZ_WINDOW))
                            r_state <= S_FIN;
                        else
                            r_state <= S_M1;
                    end
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_acc   <= r_prod[40:0];
                    r_state <= S_M3;
                end
                S_M3: r_state <= S_W_PT;
                S_W_PT: begin
                    if (sq_stat.done) begin
                        r_pt <= pt_sat;
                        if (pt_sat == '0) begin
                            if (az == '0)     r_eta <= '0;
                            else if (r_pz[19]) r_eta <= -16'sd32767;
                            else               r_eta <= 16'sd32767;
                            r_state <= S_PHI0;
                        end else begin
                            r_state <= S_M4;
                        end
                    end
                end
                S_M4: r_state <= S_M5;
                S_M5: begin
                    r_acc   <= r_prod[40:0];
                    r_state <= S_M6;
                end
                S_M6: r_state <= S_W_P;
                S_W_P: begin
                    if (sq_stat.done) begin
                        r_m     <= 32'(22'(az) + 22'(sq_root));
                        r_k     <= 5'd30;
                        r_frac  <= '0;
                        r_bit   <= 4'd15;
                        r_lsel  <= 1'b0;
                        r_state <= S_LNORM;
                    end
                end
                S_LNORM: begin
                    // normalize the mantissa to bit 30
                    if (r_m[30]) begin
                        r_state <= S_LSQ;
                    end else begin
                        r_m <= {r_m[30:0], 1'b0};
                        r_k <= r_k - 1'b1;
                    end
                end
                S_LSQ: r_state <= S_LUPD;
                S_LUPD: begin
                    if (r_bit == '0 && !r_lsel) begin
                        r_l1    <= {r_k, frac_n};
                        r_m     <= {12'b0, r_pt};
                        r_k     <= 5'd30;
                        r_frac  <= '0;
                        r_bit   <= 4'd15;
                        r_lsel  <= 1'b1;
                        r_state <= S_LNORM;
                    end else begin
                        r_m    <= mnew[31] ? {1'b0, mnew[31:1]} : mnew;
                        r_frac <= frac_n;
                        if (r_bit == '0) begin
                            r_state <= S_EMUL;
                        end else begin
                            r_bit   <= r_bit - 1'b1;
                            r_state <= S_LSQ;
                        end
                    end
                end
                S_EMUL: r_state <= S_ESET;
                S_ESET: begin
                    r_eta   <= r_pz[19] ? -$signed(eta_c) : $signed(eta_c);
                    r_state <= S_PHI0;
                end
                S_PHI0: begin
                    r_iter <= '0;
                    if (r_px == '0 && r_py == '0) begin
                        r_phi   <= '0;
                        r_state <= S_POST;
                    end else begin
                        // fold the left half plane over
                        if (r_px[19]) begin
                            r_x <= -x0;
                            r_y <= -y0;
                            r_z <= r_py[19] ? -PI_Q16 : PI_Q16;
                        end else begin
                            r_x <= x0;
                            r_y <= y0;
                            r_z <= '0;
                        end
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (r_y > 0) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + atan_q16(5'(r_iter));
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - atan_q16(5'(r_iter));
                    end
                    r_iter <= r_iter + 1'b1;
                    if (r_iter == IW'(CORDIC_STEPS - 1)) r_state <= S_PHIR;
                end
                S_PHIR: begin
                    r_phi   <= zr[19:4];
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (t_op'(r_op) == OP_ELECTRON) begin
                        r_cand_pt  <= r_pt;
                        r_cand_eta <= r_eta;
                        r_cand_phi <= r_phi;
                        r_cand_vz  <= r_vz;
                        r_sum      <= '0;
                        r_best     <= '1;
                        r_best_v   <= '1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_deta <= 17'(r_eta) - 17'(r_cand_eta);
                        if (dphi_raw > PI_Q12)       r_dphi <= dphi_raw - TWO_PI_Q12;
                        else if (dphi_raw < -PI_Q12) r_dphi <= dphi_raw + TWO_PI_Q12;
                        else                         r_dphi <= dphi_raw;
                        r_state <= S_M7;
                    end
                end
                S_M7: r_state <= S_M8;
                S_M8: begin
                    r_acc   <= r_prod[40:0];
                    r_state <= S_M9;
                end
                S_M9: r_state <= S_W_DR;
                S_W_DR: begin
                    if (sq_stat.done) begin
                        if (dr < r_outer && dr > r_inner)
                            r_sum <= sum_t[28] ? 28'hFFFFFFF : sum_t[27:0];
                        if (r_pt >= r_min_pt) begin
                            if (dr < r_best) r_best <= dr;
                            if (dr < r_best_v && dr > r_inner) r_best_v <= dr;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_cand_pt == '0) begin
                        r_ratio <= 24'hFFFFFF;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_W_DIV;
                    end
                end
                S_W_DIV: begin
                    if (dv_stat.done) begin
                        r_ratio <= ratio_sat;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_load) begin
                        r_oratio <= r_ratio;
                        r_iso    <= (r_ratio <= r_pt_cut);
                        r_omin   <= r_best;
                        r_ominv  <= r_best_v;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.pt_ratio    = r_oratio;
    assign o_out.isolated    = r_iso;
    assign o_out.min_dr      = r_omin;
    assign o_out.min_dr_veto = r_ominv;

`ifndef NO_ASSERTIONS
    a_ready_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!sq_stat.busy && !dv_stat.busy))
        else $error("item taken while a shared unit is busy");

    a_rise_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == S_OUT))
        else $error("result shown outside the output step");

    a_veto_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best_v != 16'hFFFF) |-> (r_best <= r_best_v))
        else $error("vetoed minimum below the plain minimum");
`endif

endmodule

@@ tb/sv/track_cone_isolation_tb.sv @@
// Self-checking testbench for the track cone isolation block: random tracks, scoreboard, config phases.
module track_cone_isolation_tb;
    import tci_pkg::*;

    typedef struct {
        logic [23:0] pt_ratio;
        logic        isolated;
        logic [15:0] min_dr;
        logic [15:0] min_dr_veto;
    } t_iso_res;

    // Isolation predictor and store of expected isolation results
    class iso_scoreboard;
        logic [15:0] outer_r, inner_r;
        logic [19:0] min_pt;
        logic [23:0] pt_cut;
        longint      c_eta, c_phi, c_vz;
        longint unsigned c_pt, sum, best, best_v;
        t_iso_res    pending[$];
        int          n_err;

        function void reset_state();
            outer_r = OUTER_RST; inner_r = INNER_RST;
            min_pt = MIN_PT_RST; pt_cut = PT_CUT_RST;
            c_eta = 0; c_phi = 0; c_vz = 0; c_pt = 0; sum = 0;
            best = 16'hFFFF; best_v = 16'hFFFF;
            pending.delete();
            n_err = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [23:0] v);
            case (idx)
                REG_OUTER_RADIUS: outer_r = v[15:0];
                REG_INNER_RADIUS: inner_r = v[15:0];
                REG_MIN_PT:       min_pt = v[19:0];
                REG_PT_CUT:       pt_cut = v;
                default: ;
            endcase
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned r, b;
            r = 0; b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b; r = (r >> 1) + b;
                end else r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint floor_shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint phi_calc(longint x, longint y);
            longint z, nx;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                z = (y >= 0) ? longint'(PI_Q16) : -longint'(PI_Q16);
                x = -x; y = -y;
            end
            x *= 256; y *= 256;
            for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++) begin
                if (y > 0) begin
                    nx = x + floor_shr(y, i); y = y - floor_shr(x, i);
                    z += longint'(atan_q16(i[4:0]));
                end else begin
                    nx = x - floor_shr(y, i); y = y + floor_shr(x, i);
                    z -= longint'(atan_q16(i[4:0]));
                end
                x = nx;
            end
            return floor_shr(z + 8, 4);
        endfunction

        function longint unsigned log2_fix(longint unsigned n);
            int k;
            longint unsigned m, r;
            k = 0;
            while (k < 62 && (n >> (k + 1)) != 0) k++;
            m = (k <= 30) ? (n << (30 - k)) : (n >> (k - 30));
            r = longint'(k) << 16;
            for (int b = 15; b >= 0; b--) begin
                m = (m * m) >> 30;
                if (m >= (64'd1 << 31)) begin
                    m >>= 1; r |= 64'd1 << b;
                end
            end
            return r;
        endfunction

        function longint eta_calc(longint unsigned pt, longint pz);
            longint unsigned az, p, d, e;
            az = (pz < 0) ? -pz : pz;
            if (pt == 0) return (az == 0) ? 0 : ((pz < 0) ? -32767 : 32767);
            p = root(pt * pt + az * az);
            d = log2_fix(az + p) - log2_fix(pt);
            e = (d * longint'(LN2_Q16) + (64'd1 << 19)) >> 20;
            if (e > 32767) e = 32767;
            return (pz < 0) ? -longint'(e) : longint'(e);
        endfunction

        function void note_item(logic op, logic signed [19:0] px, logic signed [19:0] py,
                                logic signed [19:0] pz, logic signed [15:0] vz, logic lst);
            longint unsigned pt, dr, ratio;
            longint eta, phi, dvz, de, dp;
            t_iso_res r;
            pt = root(longint'(px) * px + longint'(py) * py);
            if (pt > 20'hFFFFF) pt = 20'hFFFFF;
            eta = eta_calc(pt, pz);
            phi = phi_calc(px, py);
            if (op == OP_ELECTRON) begin
                c_pt = pt; c_eta = eta; c_phi = phi; c_vz = vz;
                sum = 0; best = 16'hFFFF; best_v = 16'hFFFF;
                return;
            end
            dvz = longint'(vz) - c_vz;
            if (dvz <= 200 && dvz >= -200) begin
                de = eta - c_eta;
                dp = phi - c_phi;
                if (dp > 12868) dp -= 25736;
                else if (dp < -12868) dp += 25736;
                dr = root(de * de + dp * dp);
                if (dr > 16'hFFFF) dr = 16'hFFFF;
                if (dr < outer_r && dr > inner_r) begin
                    sum += pt;
                    if (sum > 28'hFFFFFFF) sum = 28'hFFFFFFF;
                end
                if (pt >= min_pt) begin
                    if (dr < best) best = dr;
                    if (dr < best_v && dr > inner_r) best_v = dr;
                end
            end
            if (!lst) return;
            if (c_pt == 0) ratio = 24'hFFFFFF;
            else begin
                ratio = (sum << 16) / c_pt;
                if (ratio > 24'hFFFFFF) ratio = 24'hFFFFFF;
            end
            r.pt_ratio = ratio[23:0];
            r.isolated = (ratio <= pt_cut);
            r.min_dr = best[15:0];
            r.min_dr_veto = best_v[15:0];
            pending.push_back(r);
        endfunction

        function void check_result(logic [23:0] ratio, logic iso, logic [15:0] md,
                                   logic [15:0] mdv);
            t_iso_res e;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result ratio=%0d", ratio);
                return;
            end
            e = pending.pop_front();
            if (e.pt_ratio !== ratio || e.isolated !== iso || e.min_dr !== md
                    || e.min_dr_veto !== mdv) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             e.pt_ratio, e.isolated, e.min_dr, e.min_dr_veto,
                             ratio, iso, md, mdv);
            end
        endfunction
    endclass

    localparam longint CYCLE_LIMIT = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    tci_in_if  in_ch();
    tci_out_if out_ch();
    tci_cfg_if cfg_ch();

    iso_scoreboard sb;
    longint cycles = 0;
    bit     no_idle = 0;

    track_cone_isolation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    always #10 i_clk = ~i_clk;

    // result side: sample at rising edge, randomize ready at falling edge unless no_idle holds it high
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.pt_ratio, out_ch.isolated, out_ch.min_dr,
                            out_ch.min_dr_veto);
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk)
        out_ch.ready <= i_rst_n && (no_idle || $urandom_range(99) >= 31);

    task automatic send_item(logic op, logic signed [19:0] px, logic signed [19:0] py,
                             logic signed [19:0] pz, logic signed [15:0] vz, logic lst);
        while (!no_idle && $urandom_range(99) < 31) @(negedge i_clk);
        in_ch.valid = 1; in_ch.op = op; in_ch.mom_x = px; in_ch.mom_y = py;
        in_ch.mom_z = pz; in_ch.vertex_z = vz; in_ch.last = lst;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(op, px, py, pz, vz, lst);
        @(negedge i_clk);
        in_ch.valid = 0;
    endtask

    task automatic write_cfg(t_cfg_reg idx, logic [23:0] v);
        cfg_ch.valid = 1; cfg_ch.index = idx; cfg_ch.data = v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        cfg_ch.valid = 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    function automatic logic signed [19:0] rand_mom();
        case ($urandom_range(3))
            0: return 20'($urandom);
            1: return $signed(20'($urandom_range(4000))) - 20'sd2000;
            2: return $signed(20'($urandom_range(64000))) - 20'sd32000;
            default: return ($urandom_range(1)) ? 20'sh7FFFF : 20'sh80000;
        endcase
    endfunction

    // electron followed by tracks near it, with some noise tracks
    task automatic random_event(ref int n);
        logic signed [19:0] ex, ey, ez, tx, ty, tz;
        logic signed [15:0] evz, tvz;
        int ntr;
        ex = rand_mom(); ey = rand_mom(); ez = rand_mom();
        evz = 16'($urandom);
        if ($urandom_range(9) == 0) begin
            ex = 0; ey = 0;
        end
        send_item(OP_ELECTRON, ex, ey, ez, evz, 1'($urandom_range(1)));
        n++;
        ntr = $urandom_range(8);
        for (int t = 0; t <= ntr; t++) begin
            if ($urandom_range(9) < 8) begin
                tx = ex + $signed(20'($urandom_range(800))) - 20'sd400;
                ty = ey + $signed(20'($urandom_range(800))) - 20'sd400;
                tz = ez + $signed(20'($urandom_range(800))) - 20'sd400;
                tvz = evz + $signed(16'($urandom_range(440))) - 16'sd220;
            end else begin
                tx = 20'($urandom); ty = 20'($urandom); tz = 20'($urandom);
                tvz = 16'($urandom);
            end
            send_item(OP_TRACK, tx, ty, tz, tvz, (t == ntr) || ($urandom_range(19) == 0));
            n++;
        end
    endtask

    initial begin
        int n;
        in_ch.valid = 0; in_ch.op = 0; in_ch.mom_x = 0; in_ch.mom_y = 0;
        in_ch.mom_z = 0; in_ch.vertex_z = 0; in_ch.last = 0;
        cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
        sb = new();
        sb.reset_state();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        sb.reset_state();

        // directed: extremes, zero-pt cases, vertex window edges, dropped last
        send_item(OP_TRACK, 0, 0, 0, 0, 1);
        send_item(OP_ELECTRON, 20'sd6400, 0, 0, 0, 1);
        send_item(OP_TRACK, 20'sd6400, 20'sd60, 0, 16'sd200, 0);
        send_item(OP_TRACK, 20'sd6400, 20'sd200, 20'sd100, -16'sd200, 0);
        send_item(OP_TRACK, 20'sd6400, 20'sd100, 0, 16'sd201, 1);
        send_item(OP_ELECTRON, 20'sh80000, 20'sh80000, 20'sh7FFFF, 16'sh7FFF, 0);
        send_item(OP_TRACK, 20'sh7FFFF, 20'sh7FFFF, 20'sh80000, 16'sh7FFF, 0);
        send_item(OP_TRACK, 20'sh80000, 20'sd1, 0, 16'sh7FF0, 1);
        send_item(OP_TRACK, 20'sh80000, -20'sd1, 0, 16'sh7FF0, 1);
        send_item(OP_ELECTRON, 0, 0, 20'sd500, 16'sh8000, 0);
        send_item(OP_TRACK, 0, 0, -20'sd500, 16'sh8000, 0);
        send_item(OP_TRACK, 0, 20'sd30, 20'sh80000, 16'sh8000, 1);
        send_item(OP_ELECTRON, -20'sd3000, -20'sd10, 20'sd9000, 0, 0);
        send_item(OP_TRACK, -20'sd3000, 20'sd10, 20'sd9000, 0, 0);
        send_item(OP_TRACK, -20'sd2990, -20'sd40, 20'sd9010, 0, 1);
        drain();

        write_cfg(REG_OUTER_RADIUS, 24'hFFFF);
        write_cfg(REG_INNER_RADIUS, 24'd0);
        write_cfg(REG_MIN_PT, 24'hFFFFF);
        write_cfg(REG_PT_CUT, 24'hFFFFFF);
        send_item(OP_ELECTRON, 0, 0, 0, 0, 0);
        send_item(OP_TRACK, 20'sd100, 20'sd100, 0, 0, 1);
        send_item(OP_ELECTRON, 20'sd1, 0, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            send_item(OP_TRACK, 20'sh7FFFF, 20'sh7FFFF, 0, 0, i == 3);
        drain();

        n = 0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_cfg(REG_OUTER_RADIUS, OUTER_RST);
                    write_cfg(REG_INNER_RADIUS, INNER_RST);
                    write_cfg(REG_MIN_PT, MIN_PT_RST);
                    write_cfg(REG_PT_CUT, PT_CUT_RST);
                end
                1: begin
                    write_cfg(REG_OUTER_RADIUS, 24'd0);
                    write_cfg(REG_INNER_RADIUS, 24'hFFFF);
                    write_cfg(REG_PT_CUT, 24'd0);
                end
                default: begin
                    write_cfg(REG_OUTER_RADIUS, 24'($urandom_range(65535)));
                    write_cfg(REG_INNER_RADIUS, 24'($urandom_range(400)));
                    write_cfg(REG_MIN_PT, $urandom_range(3) == 0
                                          ? 24'($urandom_range(20'hFFFFF))
                                          : 24'($urandom_range(3000)));
                    write_cfg(REG_PT_CUT, $urandom_range(3) == 0
                                          ? 24'($urandom_range(24'hFFFFFF))
                                          : 24'($urandom_range(70000)));
                end
            endcase
            no_idle = (ph == 3);
            while (n < (ph + 1) * 300) random_event(n);
            no_idle = 0;
            drain();
        end
        if (sb.n_err == 0 && sb.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ sim.f @@
hdl/tci_pkg.sv
hdl/tci_if.sv
hdl/tci_sqrt.sv
hdl/tci_div.sv
hdl/track_cone_isolation.sv
tb/sv/track_cone_isolation_tb.sv
